@@ hw/rtl/free_page_stack_allocator_top_assert.svh @@
// Assertion macros for the page allocator checker.
`ifndef FREE_PAGE_STACK_ALLOCATOR_TOP_ASSERT_SVH
`define FREE_PAGE_STACK_ALLOCATOR_TOP_ASSERT_SVH

// implication in the same cycle, ignored while reset is high
`define FAP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fap check failed");

// implication in the next cycle, ignored while reset is high
`define FAP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fap check failed");

// implication in the next cycle, live through reset
`define FAP_ASSERT_RST(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("fap reset check failed");

`endif

@@ hw/rtl/fap_pkg.sv @@
`timescale 1ns / 1ps
package fap_pkg;

   localparam int MAX_FRAMES = 32768;
   localparam int ADDR_W     = 56;
   localparam int PAGE_SHIFT = 12;
   localparam int FRAME_W    = ADDR_W - PAGE_SHIFT;
   localparam int IDX_W      = $clog2(MAX_FRAMES);
   localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 2;

   localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADADDR = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

   localparam logic CSR_KERNEL_END = 1'b0;
   localparam logic CSR_PHYS_TOP   = 1'b1;

   typedef struct packed {
      logic load;     // capture accepted request word
      logic check;    // bounds compares, stack read
      logic commit;   // update stack, load response register
   } dp_cmd_type;

endpackage

@@ hw/rtl/free_page_stack_allocator_top.sv @@
`timescale 1ns / 1ps
// channel   dir  handshake              payload
// req_      in   req_tvalid/req_tready  tdata: page_addr; tuser: func
// rsp_      out  rsp_tvalid/rsp_tready  tdata: result_addr; tuser: status
// csr_      in   csr_we                 csr_index, csr_wdata
//
// Each request passes through capture, compare plus stack memory read, then commit.
// Init is one pass too: the pushed range is kept as base + slot until overwritten.
// A new request is taken while a response still waits in the output register;
// commit waits only if that register is still full.
// Synchronous active-high reset empties the stack and restores the bounds.
module free_page_stack_allocator_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [fap_pkg::ADDR_W-1:0]         req_tdata,   // [55:0] page_addr
   input  logic [fap_pkg::FUNC_W-1:0]         req_tuser,   // [1:0] func
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [fap_pkg::ADDR_W-1:0]         rsp_tdata,   // [55:0] result_addr
   output logic [fap_pkg::STATUS_W-1:0]       rsp_tuser,   // [1:0] status
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [fap_pkg::ADDR_W-1:0]         csr_wdata
);
   import fap_pkg::*;

   dp_cmd_type cmd;

   fap_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   fap_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_func        (req_tuser),
      .req_page_addr   (req_tdata),
      .rsp_result_addr (rsp_tdata),
      .rsp_status      (rsp_tuser)
   );

endmodule

@@ hw/rtl/fap_ctrl.sv @@
`timescale 1ns / 1ps
module fap_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output fap_pkg::dp_cmd_type cmd
);
   import fap_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_CHECK  = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept, commit;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   // result may land as soon as the output slot is empty or draining
   assign commit     = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;

   assign cmd.load   = accept;
   assign cmd.check  = (state_ff == S_CHECK);
   assign cmd.commit = commit;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_CHECK;
         S_CHECK:  state_in = S_FINISH;
         S_FINISH: if (commit) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (commit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hw/rtl/fap_datapath.sv @@
`timescale 1ns / 1ps
module fap_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  fap_pkg::dp_cmd_type                 cmd,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [fap_pkg::ADDR_W-1:0]          csr_wdata,
   input  logic [fap_pkg::FUNC_W-1:0]          req_func,
   input  logic [fap_pkg::ADDR_W-1:0]          req_page_addr,
   output logic [fap_pkg::ADDR_W-1:0]          rsp_result_addr,
   output logic [fap_pkg::STATUS_W-1:0]        rsp_status
);
   import fap_pkg::*;

   localparam logic [ADDR_W-1:0]  KERNEL_END_RST = 56'h0000_0080_000000;
   localparam logic [ADDR_W-1:0]  PHYS_TOP_RST   = 56'h0000_0088_000000;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = COUNT_W'(MAX_FRAMES);
   localparam logic [FRAME_W:0]   SPAN_MAX       = (FRAME_W + 1)'(MAX_FRAMES);
   localparam logic [ADDR_W:0]    PAGE_ROUND     = (ADDR_W + 1)'((1 << PAGE_SHIFT) - 1);

   logic [FRAME_W-1:0] frames_mem [MAX_FRAMES];

   logic [ADDR_W-1:0]   kernel_end_ff, phys_top_ff;
   logic [FUNC_W-1:0]   func_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [COUNT_W-1:0]  count_ff, count_in;
   // stack slots below init_hi still hold init_base + slot, never rewritten
   logic [COUNT_W-1:0]  init_hi_ff, init_hi_in;
   logic [FRAME_W-1:0]  init_base_ff, init_base_in;
   logic [FRAME_W:0]    first_ff;
   logic                below_ff, over_ff;
   logic [FRAME_W-1:0]  rd_data_ff;
   logic                pop_init_ff;
   logic [FRAME_W-1:0]  pop_init_frame_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [ADDR_W:0]     round_sum;
   logic [COUNT_W-1:0]  pop_pos;
   logic [FRAME_W:0]    limit, span;
   logic [COUNT_W-1:0]  take;
   logic                too_many;
   logic                push_en;
   logic [FRAME_W-1:0]  pop_frame;

   assign round_sum = {1'b0, kernel_end_ff} + PAGE_ROUND;
   assign pop_pos   = count_ff - COUNT_W'(1);

   // init range size
   assign limit    = {1'b0, phys_top_ff[ADDR_W-1:PAGE_SHIFT]};
   assign span     = limit - first_ff;
   assign too_many = (limit > first_ff) && (span > SPAN_MAX);
   always_comb begin
      if (limit <= first_ff) take = '0;
      else if (too_many)     take = COUNT_MAX;
      else                   take = span[COUNT_W-1:0];
   end

   assign pop_frame = pop_init_ff ? pop_init_frame_ff : rd_data_ff;

   always_comb begin
      count_in      = count_ff;
      init_hi_in    = init_hi_ff;
      init_base_in  = init_base_ff;
      rsp_addr_in   = '0;
      rsp_status_in = ST_OK;
      push_en       = 1'b0;
      unique case (func_ff)
         FUNC_INIT: begin
            count_in      = take;
            init_hi_in    = take;
            init_base_in  = first_ff[FRAME_W-1:0];
            rsp_status_in = too_many ? ST_FULL : ST_OK;
         end
         FUNC_FREE: begin
            if (addr_ff[PAGE_SHIFT-1:0] != '0 || below_ff || over_ff) begin
               rsp_status_in = ST_BADADDR;
            end else if (count_ff >= COUNT_MAX) begin
               rsp_status_in = ST_FULL;
            end else begin
               push_en  = 1'b1;
               count_in = count_ff + COUNT_W'(1);
               if (count_ff < init_hi_ff) init_hi_in = count_ff;
            end
         end
         FUNC_ALLOC: begin
            if (count_ff == '0) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               count_in    = pop_pos;
               rsp_addr_in = {pop_frame, {PAGE_SHIFT{1'b0}}};
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_end_ff <= KERNEL_END_RST;
         phys_top_ff   <= PHYS_TOP_RST;
         count_ff      <= '0;
         init_hi_ff    <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_KERNEL_END: kernel_end_ff <= csr_wdata;
               CSR_PHYS_TOP:   phys_top_ff   <= csr_wdata;
               default:        kernel_end_ff <= kernel_end_ff;
            endcase
         end
         if (cmd.commit) begin
            count_ff   <= count_in;
            init_hi_ff <= init_hi_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         addr_ff <= req_page_addr;
      end
      if (cmd.check) begin
         first_ff          <= round_sum[ADDR_W:PAGE_SHIFT];
         below_ff          <= addr_ff < kernel_end_ff;
         over_ff           <= addr_ff >= phys_top_ff;
         pop_init_ff       <= pop_pos < init_hi_ff;
         pop_init_frame_ff <= init_base_ff + FRAME_W'(pop_pos);
      end
      if (cmd.commit) begin
         init_base_ff  <= init_base_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // stack memory: one read in the check cycle, one write at commit of an accepted free
   always_ff @(posedge clock) begin
      if (cmd.check) rd_data_ff <= frames_mem[pop_pos[IDX_W-1:0]];
      if (cmd.commit && push_en) frames_mem[count_ff[IDX_W-1:0]] <= addr_ff[ADDR_W-1:PAGE_SHIFT];
   end

   assign rsp_result_addr = rsp_addr_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

@@ hw/rtl/fap_checker.sv @@
`timescale 1ns / 1ps
`include "free_page_stack_allocator_top_assert.svh"
module fap_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [fap_pkg::ADDR_W-1:0]    rsp_tdata,
   input logic [fap_pkg::STATUS_W-1:0]  rsp_tuser
);
   import fap_pkg::*;

   `FAP_ASSERT_RST(a_reset_clears_rsp, reset, !rsp_tvalid)
   `FAP_ASSERT_NEXT(a_rsp_holds, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `FAP_ASSERT_NOW(a_err_zero_addr, rsp_tvalid && rsp_tuser != ST_OK, rsp_tdata == '0)
   `FAP_ASSERT_NOW(a_page_aligned, rsp_tvalid, rsp_tdata[PAGE_SHIFT-1:0] == '0)
   `FAP_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)

endmodule

bind free_page_stack_allocator_top fap_checker u_fap_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
